/* src/owbm_pkg.sv */
package owbm_pkg;

   // Configuration register file
   localparam int NUM_REGS  = 8;
   localparam int REG_BITS  = 10;
   localparam int REG_IDX_BITS = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_RESET_REC     = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_SLOT_START    = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_WRITE_HOLD    = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_SLOT_REC      = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_READ_SAMPLE   = 3'd6;
   localparam logic [REG_IDX_BITS-1:0] REG_READ_TAIL     = 3'd7;

   // Reset values, index 7 in the top slot
   localparam logic [NUM_REGS-1:0][REG_BITS-1:0] REG_RESET_VALUE = {
      10'd49, 10'd10, 10'd1, 10'd58, 10'd2, 10'd380, 10'd100, 10'd480
   };

   // Registers that may legally hold zero (the phase is skipped)
   localparam logic [NUM_REGS-1:0] REG_ZERO_OK = 8'b1010_0000;

   // Command modes
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_RESET = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RST_REC  = 4'd3,
      PH_SLOT_LOW = 4'd4,
      PH_WR_HOLD  = 4'd5,
      PH_WR_REC   = 4'd6,
      PH_RD_WAIT  = 4'd7,
      PH_RD_TAIL  = 4'd8
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic       line_in;
   } req_word_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_byte;
   } rsp_word_type;

endpackage

/* src/owbm_csr.sv */
module owbm_csr #(
   parameter int TIMER_BITS = 10
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_wr_en,
   input  logic [owbm_pkg::REG_IDX_BITS-1:0]              csr_index,
   input  logic [owbm_pkg::REG_BITS-1:0]                  csr_wr_data,
   output logic [owbm_pkg::NUM_REGS-1:0][TIMER_BITS-1:0]  dur
);

   localparam logic [16:0] TIMER_MAX = 17'((1 << TIMER_BITS) - 1);

   logic [owbm_pkg::NUM_REGS-1:0][owbm_pkg::REG_BITS-1:0] regs_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= owbm_pkg::REG_RESET_VALUE;
      end else if (csr_wr_en) begin
         regs_ff[csr_index] <= csr_wr_data;
      end
   end

   // Effective durations: raise zero to one where required, saturate to timer
   always_comb begin
      logic [16:0] d;
      for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
         d = {7'd0, regs_ff[i]};
         if (d == 17'd0 && !owbm_pkg::REG_ZERO_OK[i]) begin
            d = 17'd1;
         end
         if (d > TIMER_MAX) begin
            d = TIMER_MAX;
         end
         dur[i] = d[TIMER_BITS-1:0];
      end
   end

endmodule

/* src/owbm_seq.sv */
module owbm_seq #(
   parameter int TIMER_BITS = 10
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          step,
   input  owbm_pkg::req_word_type                         req,
   input  logic [owbm_pkg::NUM_REGS-1:0][TIMER_BITS-1:0]  dur,
   output owbm_pkg::rsp_word_type                         rsp
);

   owbm_pkg::phase_type   phase_ff, phase_in;
   logic [TIMER_BITS-1:0] tick_ff, tick_in;
   logic [2:0]            bit_ff, bit_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  presence_ff, presence_in;
   logic [1:0]            kind_ff, kind_in;
   logic [7:0]            last_read_ff, last_read_in;

   logic [TIMER_BITS-1:0] cur_dur;
   logic                  last_tick;
   logic                  end_bit;
   logic                  finish;
   logic                  drive;

   // Sequencer state, advanced once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= owbm_pkg::PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         presence_ff  <= 1'b0;
         kind_ff      <= owbm_pkg::MODE_TICK;
         last_read_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         presence_ff  <= presence_in;
         kind_ff      <= kind_in;
         last_read_ff <= last_read_in;
      end
   end

   // Next state and result of one tick
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      presence_in  = presence_ff;
      kind_in      = kind_ff;
      last_read_in = last_read_ff;
      cur_dur      = '0;
      last_tick    = 1'b0;
      end_bit      = 1'b0;
      finish       = 1'b0;
      drive        = 1'b0;

      // command start: this tick is already the first tick of the first phase
      if (phase_ff == owbm_pkg::PH_IDLE && req.mode != owbm_pkg::MODE_TICK) begin
         kind_in = req.mode;
         bit_in  = '0;
         tick_in = '0;
         if (req.mode == owbm_pkg::MODE_RESET) begin
            phase_in = owbm_pkg::PH_RST_LOW;
         end else begin
            phase_in = owbm_pkg::PH_SLOT_LOW;
            shift_in = (req.mode == owbm_pkg::MODE_WRITE) ? req.data_byte : 8'd0;
         end
      end

      if (phase_in != owbm_pkg::PH_IDLE) begin
         cur_dur   = dur[3'(4'(phase_in) - 4'd1)];
         last_tick = (({1'b0, tick_in} + (TIMER_BITS+1)'(1)) >= {1'b0, cur_dur});

         // line drive: low pulse, or written zero held low
         case (phase_in) inside
            owbm_pkg::PH_RST_LOW,
            owbm_pkg::PH_SLOT_LOW: drive = 1'b1;
            owbm_pkg::PH_WR_HOLD:  drive = ~shift_in[0];
            default:               drive = 1'b0;
         endcase

         // samples on the last tick of their wait phase
         if (last_tick && phase_in == owbm_pkg::PH_RST_WAIT) begin
            presence_in = ~req.line_in;
         end
         if (last_tick && phase_in == owbm_pkg::PH_RD_WAIT) begin
            shift_in = {req.line_in, shift_in[7:1]};
         end

         tick_in = tick_in + TIMER_BITS'(1);

         if (last_tick) begin
            tick_in = '0;
            unique case (phase_in) inside
               owbm_pkg::PH_RST_LOW:  phase_in = owbm_pkg::PH_RST_WAIT;
               owbm_pkg::PH_RST_WAIT: phase_in = owbm_pkg::PH_RST_REC;
               owbm_pkg::PH_SLOT_LOW:
                  phase_in = (kind_in == owbm_pkg::MODE_WRITE) ?
                             owbm_pkg::PH_WR_HOLD : owbm_pkg::PH_RD_WAIT;
               owbm_pkg::PH_WR_HOLD: begin
                  // zero recovery skips straight to the end of the slot
                  if (dur[owbm_pkg::REG_SLOT_REC] == '0) begin
                     end_bit = 1'b1;
                  end else begin
                     phase_in = owbm_pkg::PH_WR_REC;
                  end
               end
               owbm_pkg::PH_RD_WAIT: begin
                  if (dur[owbm_pkg::REG_READ_TAIL] == '0) begin
                     end_bit = 1'b1;
                  end else begin
                     phase_in = owbm_pkg::PH_RD_TAIL;
                  end
               end
               owbm_pkg::PH_WR_REC,
               owbm_pkg::PH_RD_TAIL: end_bit = 1'b1;
               default:              finish = 1'b1;
            endcase

            // end of a bit slot
            if (end_bit) begin
               if (bit_in == owbm_pkg::LAST_BIT) begin
                  finish = 1'b1;
                  if (kind_in == owbm_pkg::MODE_READ) begin
                     last_read_in = shift_in;
                  end
               end else begin
                  bit_in = bit_in + 3'd1;
                  if (kind_in == owbm_pkg::MODE_WRITE) begin
                     shift_in = {1'b0, shift_in[7:1]};
                  end
                  phase_in = owbm_pkg::PH_SLOT_LOW;
               end
            end

            if (finish) begin
               phase_in = owbm_pkg::PH_IDLE;
            end
         end
      end

      rsp.drive_low = drive;
      rsp.busy_res  = (cur_dur != '0) || (phase_ff != owbm_pkg::PH_IDLE) ||
                      (req.mode != owbm_pkg::MODE_TICK);
      rsp.done_res  = finish;
      rsp.presence  = presence_in;
      rsp.read_byte = last_read_in;
   end

endmodule

/* src/one_wire_bus_master_top.sv */
// 1-Wire bus master. Every accepted req word is one timing tick (normally one
// microsecond) and yields exactly one rsp word, in order. A new word can be
// taken every clock cycle unless the receiver stalls the result; a word passes
// the input register and then the result register, with the sequencer's
// single-pass next-state logic between them. Commands (reset with presence
// detect, byte write, byte read, LSB first) are taken only while idle; a
// command word during a command is treated as a plain tick. Slot timing is
// set by the eight csr registers, which should be written only while idle.
module one_wire_bus_master_top #(
   parameter int TIMER_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  owbm_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output owbm_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_wr_en,
   input  logic [owbm_pkg::REG_IDX_BITS-1:0]    csr_index,
   input  logic [owbm_pkg::REG_BITS-1:0]        csr_wr_data
);

   logic                                          in_valid_ff;
   owbm_pkg::req_word_type                        req_ff;
   logic                                          out_valid_ff;
   owbm_pkg::rsp_word_type                        rsp_ff;
   owbm_pkg::rsp_word_type                        rsp_in;
   logic                                          step;
   logic [owbm_pkg::NUM_REGS-1:0][TIMER_BITS-1:0] dur;

   // Advance when a word is held and the result slot is free or draining
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = rsp_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_word;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   owbm_csr #(
      .TIMER_BITS(TIMER_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .dur        (dur)
   );

   owbm_seq #(
      .TIMER_BITS(TIMER_BITS)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .step (step),
      .req  (req_ff),
      .dur  (dur),
      .rsp  (rsp_in)
   );

   // A processed word always lands in the result register
   a_step_fills_out: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("processed word did not reach result register");

   // A finishing tick is part of the command
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.done_res |-> rsp_word.busy_res)
      else $error("done without busy");

   // The line is only pulled low during a command
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.drive_low |-> rsp_word.busy_res)
      else $error("line driven while idle");

   // A held input word waits unchanged until processed
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(req_ff))
      else $error("held input word lost");

endmodule

/* dv/owbm_checker.sv */
// Watches the req, rsp and csr ports of the bus master, predicts every rsp
// word from the accepted req words and compares them in order.
module owbm_checker #(
   parameter int TIMER_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  owbm_pkg::req_word_type            req_word,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  owbm_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_wr_en,
   input  logic [owbm_pkg::REG_IDX_BITS-1:0] csr_index,
   input  logic [owbm_pkg::REG_BITS-1:0]     csr_wr_data,
   output int                                mismatch_count,
   output int                                words_in_flight,
   output logic                              master_idle
);

   localparam int TIMER_MAX = (1 << TIMER_BITS) - 1;

   // Shadow copy of the timing registers and sequencer state
   logic [owbm_pkg::REG_BITS-1:0] timing_reg [owbm_pkg::NUM_REGS];
   owbm_pkg::phase_type           seq_phase;
   int                            tick_cnt;
   logic [2:0]                    bit_cnt;
   logic [7:0]                    shifter;
   logic                          presence_seen;
   logic [1:0]                    cmd_kind;
   logic [7:0]                    last_read_byte;

   // Predicted rsp words, oldest first
   owbm_pkg::rsp_word_type        bus_rsp_q [$];
   int                            rsp_seen;

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("MISMATCH rsp word %0d %s: got %0h expected %0h", rsp_seen, what,
               got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // Length in ticks of a phase, after the zero floor and the timer ceiling
   function automatic int phase_length(input owbm_pkg::phase_type ph);
      int idx;
      int len;
      case (ph)
         owbm_pkg::PH_RST_LOW:  idx = int'(owbm_pkg::REG_RESET_LOW);
         owbm_pkg::PH_RST_WAIT: idx = int'(owbm_pkg::REG_PRESENCE_WAIT);
         owbm_pkg::PH_RST_REC:  idx = int'(owbm_pkg::REG_RESET_REC);
         owbm_pkg::PH_SLOT_LOW: idx = int'(owbm_pkg::REG_SLOT_START);
         owbm_pkg::PH_WR_HOLD:  idx = int'(owbm_pkg::REG_WRITE_HOLD);
         owbm_pkg::PH_WR_REC:   idx = int'(owbm_pkg::REG_SLOT_REC);
         owbm_pkg::PH_RD_WAIT:  idx = int'(owbm_pkg::REG_READ_SAMPLE);
         owbm_pkg::PH_RD_TAIL:  idx = int'(owbm_pkg::REG_READ_TAIL);
         default:               return 1;
      endcase
      len = int'(timing_reg[idx]);
      if (len == 0 && !owbm_pkg::REG_ZERO_OK[idx])
         len = 1;
      if (len > TIMER_MAX)
         len = TIMER_MAX;
      return len;
   endfunction

   // End of a bit slot; 1 when the byte is complete
   function automatic bit close_bit();
      if (bit_cnt >= owbm_pkg::LAST_BIT) begin
         if (cmd_kind == owbm_pkg::MODE_READ)
            last_read_byte = shifter;
         return 1'b1;
      end
      bit_cnt = bit_cnt + 3'd1;
      if (cmd_kind == owbm_pkg::MODE_WRITE)
         shifter = shifter >> 1;
      seq_phase = owbm_pkg::PH_SLOT_LOW;
      return 1'b0;
   endfunction

   // Move to the next phase; 1 when the command is complete
   function automatic bit leave_phase();
      case (seq_phase) inside
         owbm_pkg::PH_RST_LOW:  seq_phase = owbm_pkg::PH_RST_WAIT;
         owbm_pkg::PH_RST_WAIT: seq_phase = owbm_pkg::PH_RST_REC;
         owbm_pkg::PH_SLOT_LOW:
            seq_phase = (cmd_kind == owbm_pkg::MODE_WRITE) ?
                        owbm_pkg::PH_WR_HOLD : owbm_pkg::PH_RD_WAIT;
         owbm_pkg::PH_WR_HOLD:  seq_phase = owbm_pkg::PH_WR_REC;
         owbm_pkg::PH_RD_WAIT:  seq_phase = owbm_pkg::PH_RD_TAIL;
         owbm_pkg::PH_WR_REC, owbm_pkg::PH_RD_TAIL: return close_bit();
         default:               return 1'b1;
      endcase
      return 1'b0;
   endfunction

   // One timing tick of the bus master
   function automatic owbm_pkg::rsp_word_type step_sequencer(
      input owbm_pkg::req_word_type w);
      owbm_pkg::rsp_word_type r;
      bit                     slot_end;
      bit                     finished;
      r = '0;
      if (seq_phase == owbm_pkg::PH_IDLE && w.mode != owbm_pkg::MODE_TICK) begin
         cmd_kind = w.mode;
         bit_cnt  = '0;
         tick_cnt = 0;
         if (w.mode == owbm_pkg::MODE_RESET) begin
            seq_phase = owbm_pkg::PH_RST_LOW;
         end else begin
            seq_phase = owbm_pkg::PH_SLOT_LOW;
            shifter   = (w.mode == owbm_pkg::MODE_WRITE) ? w.data_byte : 8'h00;
         end
      end
      if (seq_phase != owbm_pkg::PH_IDLE) begin
         slot_end   = (tick_cnt + 1 >= phase_length(seq_phase));
         r.busy_res = 1'b1;
         case (seq_phase) inside
            owbm_pkg::PH_RST_LOW, owbm_pkg::PH_SLOT_LOW: r.drive_low = 1'b1;
            owbm_pkg::PH_WR_HOLD:                        r.drive_low = ~shifter[0];
            default:                                     r.drive_low = 1'b0;
         endcase
         if (slot_end && seq_phase == owbm_pkg::PH_RST_WAIT)
            presence_seen = ~w.line_in;
         if (slot_end && seq_phase == owbm_pkg::PH_RD_WAIT)
            shifter = {w.line_in, shifter[7:1]};
         tick_cnt = (tick_cnt + 1) & TIMER_MAX;
         if (slot_end) begin
            tick_cnt = 0;
            finished = leave_phase();
            // zero-length recovery and tail phases are skipped
            while (!finished && phase_length(seq_phase) == 0)
               finished = leave_phase();
            if (finished) begin
               seq_phase  = owbm_pkg::PH_IDLE;
               r.done_res = 1'b1;
            end
         end
      end
      r.presence  = presence_seen;
      r.read_byte = last_read_byte;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < owbm_pkg::NUM_REGS; i++)
            timing_reg[i] = owbm_pkg::REG_RESET_VALUE[i];
         seq_phase      = owbm_pkg::PH_IDLE;
         tick_cnt       = 0;
         bit_cnt        = '0;
         shifter        = '0;
         presence_seen  = 1'b0;
         cmd_kind       = owbm_pkg::MODE_TICK;
         last_read_byte = '0;
         bus_rsp_q.delete();
      end else begin
         if (csr_wr_en)
            timing_reg[csr_index] = csr_wr_data;
         // compare the delivered word with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (bus_rsp_q.size() == 0) begin
               report_mismatch("word with nothing predicted", 8'h00, 8'h00);
            end else begin
               check_field("drive_low", 8'(rsp_word.drive_low),
                           8'(bus_rsp_q[0].drive_low));
               check_field("busy_res", 8'(rsp_word.busy_res),
                           8'(bus_rsp_q[0].busy_res));
               check_field("done_res", 8'(rsp_word.done_res),
                           8'(bus_rsp_q[0].done_res));
               check_field("presence", 8'(rsp_word.presence),
                           8'(bus_rsp_q[0].presence));
               check_field("read_byte", rsp_word.read_byte, bus_rsp_q[0].read_byte);
               void'(bus_rsp_q.pop_front());
            end
            rsp_seen++;
         end
         if (req_valid && req_ready)
            bus_rsp_q.push_back(step_sequencer(req_word));
      end
      words_in_flight = bus_rsp_q.size();
      master_idle     = (seq_phase == owbm_pkg::PH_IDLE);
   end

endmodule

/* dv/testbench.sv */
// Stimulus for the bus master: timing register settings, commands with
// their filler ticks, idle bursts on both channels and the final verdict.
module testbench;

   localparam int TIMER_BITS  = 10;
   localparam int CYCLE_LIMIT = 100000;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_CMDS  = 3;
   localparam int REG_W       = owbm_pkg::REG_BITS;

   typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_policy_type;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_valid   = 1'b0;
   logic                              req_ready;
   owbm_pkg::req_word_type            req_word    = '0;
   logic                              rsp_valid;
   logic                              rsp_ready   = 1'b0;
   owbm_pkg::rsp_word_type            rsp_word;
   logic                              csr_wr_en   = 1'b0;
   logic [owbm_pkg::REG_IDX_BITS-1:0] csr_index   = '0;
   logic [owbm_pkg::REG_BITS-1:0]     csr_wr_data = '0;

   int                                mismatch_count;
   int                                words_in_flight;
   logic                              master_idle;

   logic                              gaps_on      = 1'b1;
   logic                              hold_request = 1'b0;
   logic                              hold_taken   = 1'b0;
   int                                cycle_count  = 0;
   logic [owbm_pkg::REG_BITS-1:0]     timing_set [owbm_pkg::NUM_REGS];

   one_wire_bus_master_top #(.TIMER_BITS(TIMER_BITS)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   owbm_checker #(.TIMER_BITS(TIMER_BITS)) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word        (rsp_word),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight),
      .master_idle     (master_idle)
   );

   always #4 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: short random stalls, and one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            rsp_ready <= 1'b0;
            hold_taken = 1'b1;
            repeat (80) @(negedge clock);
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one req word and wait until it is taken; returns at a falling edge
   task automatic drive_req(input logic [1:0] mode, input logic [7:0] data,
                            input logic line);
      owbm_pkg::req_word_type w;
      w.mode      = mode;
      w.data_byte = data;
      w.line_in   = line;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic logic pick_line(input line_policy_type policy);
      case (policy)
         LINE_LOW:  return 1'b0;
         LINE_HIGH: return 1'b1;
         default:   return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // Command word, then ticks until the sequencer is idle again. Filler ticks
   // now and then carry a command, which the busy master must ignore.
   task automatic run_command(input logic [1:0] mode, input logic [7:0] data,
                              input line_policy_type policy);
      logic [1:0] tick_mode;
      drive_req(mode, data, pick_line(policy));
      while (!master_idle) begin
         tick_mode = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) :
                     owbm_pkg::MODE_TICK;
         drive_req(tick_mode, 8'($urandom_range(0, 255)), pick_line(policy));
      end
   endtask

   // Stop offering and wait for every predicted word to come back
   task automatic drain();
      req_valid <= 1'b0;
      while (words_in_flight != 0) @(negedge clock);
   endtask

   // Write all timing registers from timing_set, one per cycle
   task automatic load_timing();
      for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= i[owbm_pkg::REG_IDX_BITS-1:0];
         csr_wr_data <= timing_set[i];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_command();
      int              sel;
      logic [1:0]      mode;
      line_policy_type policy;
      sel  = $urandom_range(0, 99);
      mode = (sel < 30) ? owbm_pkg::MODE_RESET :
             (sel < 65) ? owbm_pkg::MODE_WRITE : owbm_pkg::MODE_READ;
      sel  = $urandom_range(0, 9);
      policy = (sel == 0) ? LINE_LOW : (sel == 1) ? LINE_HIGH : LINE_RANDOM;
      // occasional plain ticks while idle
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 2))
            run_command(owbm_pkg::MODE_TICK, 8'($urandom_range(0, 255)), policy);
      run_command(mode, 8'($urandom_range(0, 255)), policy);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Idle ticks at reset-value timing
      run_command(owbm_pkg::MODE_TICK, 8'hFF, LINE_LOW);
      run_command(owbm_pkg::MODE_TICK, 8'h00, LINE_HIGH);
      drain();

      // All zero: required phases floor at one tick, optional ones are skipped
      for (int i = 0; i < owbm_pkg::NUM_REGS; i++)
         timing_set[i] = '0;
      load_timing();
      run_command(owbm_pkg::MODE_RESET, 8'h00, LINE_LOW);
      run_command(owbm_pkg::MODE_WRITE, 8'h5A, LINE_RANDOM);
      run_command(owbm_pkg::MODE_READ, 8'h00, LINE_RANDOM);
      run_command(owbm_pkg::MODE_READ, 8'h00, LINE_RANDOM);
      // reset must keep the last read byte
      run_command(owbm_pkg::MODE_RESET, 8'h00, LINE_HIGH);
      drain();

      // Random phases with short timings; last ones without idling
      for (int p = 0; p < RAND_PHASES; p++) begin
         for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
            case ($urandom_range(0, 9))
               0:       timing_set[i] = '0;
               1:       timing_set[i] = REG_W'($urandom_range(4, 10));
               default: timing_set[i] = REG_W'($urandom_range(1, 3));
            endcase
         end
         if (p == RAND_PHASES - 2)
            gaps_on = 1'b0;
         load_timing();
         if (p == 1)
            hold_request = 1'b1;
         repeat (PHASE_CMDS) random_command();
         drain();
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
src/owbm_pkg.sv
src/owbm_csr.sv
src/owbm_seq.sv
src/one_wire_bus_master_top.sv
dv/owbm_checker.sv
dv/testbench.sv
